### rtl/bscf_pkg.sv
// Shared constants, types and helpers for the bitmap set/clear/find engine.
`timescale 1ns / 1ps
`default_nettype none

package bscf_pkg;

  localparam int MAP_BITS  = 4096;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 12;
  localparam int LIMIT_W = 13;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WORD_W  = $clog2(NUM_WORDS);
  localparam int LWORD_W = LIMIT_W - BIT_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_SET        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TEST       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND_SET   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND_CLEAR = 3'd4;

  localparam logic [PADDR_W-3:0] REG_BITS_IN_USE = 1'b0;

  localparam logic [LIMIT_W-1:0] BITS_IN_USE_RESET = 13'd4096;
  localparam logic [LIMIT_W-1:0] MAP_LIMIT         = LIMIT_W'(MAP_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  // index of the lowest set bit; zero when the word is empty
  function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### rtl/bscf_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

interface bscf_req_if import bscf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;

  modport source (output valid, output kind, output position, input ready);
  modport sink   (input valid, input kind, input position, output ready);
endinterface

interface bscf_rsp_if import bscf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               old_bit;
  logic [LIMIT_W-1:0] found_position;

  modport source (output valid, output old_bit, output found_position, input ready);
  modport sink   (input valid, input old_bit, input found_position, output ready);
endinterface

`default_nettype wire

### rtl/bscf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module bscf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bscf_cfg.sv
// APB register block holding the search limit.
`timescale 1ns / 1ps
`default_nettype none

module bscf_cfg import bscf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [LIMIT_W-1:0] limit
);

  logic [LIMIT_W-1:0]   bits_in_use;
  logic [PADDR_W-3:0]   reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_BITS_IN_USE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= BITS_IN_USE_RESET;
    end else if (wr_en) begin
      bits_in_use <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_BITS_IN_USE) ?
                  {{(PDATA_W-LIMIT_W){1'b0}}, bits_in_use} : '0;

  // saturate to the map size
  assign limit = (bits_in_use > MAP_LIMIT) ? MAP_LIMIT : bits_in_use;

endmodule

`default_nettype wire

### rtl/bscf_engine.sv
// Request sequencer: read-modify-write of bitmap words and word-by-word scan.
`timescale 1ns / 1ps
`default_nettype none

module bscf_engine import bscf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  bscf_req_if.sink                req,
  bscf_rsp_if.source              rsp,
  input  wire logic [LIMIT_W-1:0] limit
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state, state_next;
  logic [KIND_W-1:0]  kind_q;
  logic [BIT_W-1:0]   off_q;
  logic [WORD_W-1:0]  word_q;
  logic               first_q;
  logic [NUM_WORDS-1:0] valid_bits;
  logic               vld_q;

  logic               res_old;
  logic [LIMIT_W-1:0] res_found;
  logic               out_valid;
  logic               out_old;
  logic [LIMIT_W-1:0] out_found;

  logic               accept, slot_free;
  logic               in_bitop, in_find, start_past;
  logic [WORD_W-1:0]  in_word, rd_addr;
  logic [BIT_W-1:0]   in_off;
  word_t              rd_data, word_data, cand, low_mask, lim_mask, hit, bit_sel, wr_word;
  logic [LWORD_W-1:0] word_ext, word_p1, lim_word;
  logic [BIT_W-1:0]   lim_bit, hit_idx;
  logic [LIMIT_W-1:0] next_base;
  logic               q_bitop, any_hit, scan_end;
  logic               fin, fin_old, ram_we, advance;
  logic [LIMIT_W-1:0] fin_found;

  bscf_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_q),
    .wdata (wr_word),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;

  assign in_word    = req.position[POS_W-1:BIT_W];
  assign in_off     = req.position[BIT_W-1:0];
  assign in_bitop   = (req.kind == KIND_SET) || (req.kind == KIND_CLEAR) ||
                      (req.kind == KIND_TEST);
  assign in_find    = (req.kind == KIND_FIND_SET) || (req.kind == KIND_FIND_CLEAR);
  assign start_past = {1'b0, req.position} >= limit;

  // words never written since reset read as zero
  assign word_data = rd_data & {WORD_BITS{vld_q}};
  assign q_bitop   = (kind_q == KIND_SET) || (kind_q == KIND_CLEAR) ||
                     (kind_q == KIND_TEST);
  assign bit_sel   = word_t'(1) << off_q;
  assign wr_word   = (kind_q == KIND_SET) ? (word_data | bit_sel) : (word_data & ~bit_sel);

  assign cand      = (kind_q == KIND_FIND_SET) ? word_data : ~word_data;
  assign low_mask  = first_q ? ({WORD_BITS{1'b1}} << off_q) : {WORD_BITS{1'b1}};
  assign lim_word  = limit[LIMIT_W-1:BIT_W];
  assign lim_bit   = limit[BIT_W-1:0];
  assign word_ext  = {1'b0, word_q};
  assign lim_mask  = (word_ext < lim_word)  ? {WORD_BITS{1'b1}} :
                     (word_ext == lim_word) ? ~({WORD_BITS{1'b1}} << lim_bit) : '0;
  assign hit       = cand & low_mask & lim_mask;
  assign any_hit   = |hit;
  assign hit_idx   = lowest_set(hit);
  assign word_p1   = word_ext + LWORD_W'(1);
  assign next_base = {word_p1, {BIT_W{1'b0}}};
  assign scan_end  = next_base >= limit;

  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_old    = 1'b0;
    fin_found  = '0;
    ram_we     = 1'b0;
    advance    = 1'b0;
    rd_addr    = in_word;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_bitop || (in_find && !start_past)) begin
            state_next = ST_EVAL;
          end else begin
            fin = 1'b1;
            if (in_find) fin_found = limit;
          end
        end
      end
      ST_EVAL: begin
        if (q_bitop) begin
          fin     = 1'b1;
          fin_old = word_data[off_q];
          ram_we  = (kind_q != KIND_TEST);
        end else if (any_hit) begin
          fin       = 1'b1;
          fin_found = {1'b0, word_q, hit_idx};
        end else if (scan_end) begin
          fin       = 1'b1;
          fin_found = limit;
        end else begin
          advance = 1'b1;
          rd_addr = word_q + WORD_W'(1);
        end
      end
      ST_DONE: begin
        fin       = 1'b1;
        fin_old   = res_old;
        fin_found = res_found;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (fin) state_next = slot_free ? ST_IDLE : ST_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      state <= state_next;
      if (fin && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) valid_bits[word_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= valid_bits[rd_addr];
    if (accept) begin
      kind_q  <= req.kind;
      off_q   <= in_off;
      word_q  <= in_word;
      first_q <= 1'b1;
    end else if (advance) begin
      word_q  <= word_q + WORD_W'(1);
      first_q <= 1'b0;
    end
    if (fin && slot_free) begin
      out_old   <= fin_old;
      out_found <= fin_found;
    end
    if (fin && !slot_free) begin
      res_old   <= fin_old;
      res_found <= fin_found;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.old_bit        = out_old;
  assign rsp.found_position = out_found;

endmodule

`default_nettype wire

### rtl/bitmap_set_clear_find_engine_unit.sv
// Bitmap set/clear/test/find engine, top level.
//
// Requests arrive on req (kind, position), one response per request leaves on
// rsp (old_bit, found_position); both are valid/ready channels, a beat moves
// when valid and ready are high at a rising edge. The APB port holds
// bits_in_use at byte address 0, the search limit (saturated to the map size).
// Write it only while no request is in flight.
//
// The 4096-bit map sits in a 128 x 32 RAM with registered read. Set, clear and
// test read the word, then modify and write it back and register the response.
// A find reads one word per cycle from the start word and stops at the first
// match or at the last word below the limit. A find starting at or past the
// limit, and an unused kind, answer from the idle state without reading the
// map. A new request is taken the cycle after the previous one's result is
// registered, so one request is in progress at a time.
//
// Reset clears the map at once through per-word valid bits, and sets
// bits_in_use to 4096. The response sits in an output register; while the
// receiver stalls, the next request is still taken and its result held until
// the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_set_clear_find_engine_unit import bscf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  bscf_req_if.sink                req,
  bscf_rsp_if.source              rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [LIMIT_W-1:0] limit;

  bscf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  bscf_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .limit (limit)
  );

endmodule

`default_nettype wire

### rtl/bscf_checker.sv
// Port-level checks for the bitmap engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bscf_checker import bscf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic               rsp_old_bit,
  input wire logic [LIMIT_W-1:0] rsp_found_position,
  input wire logic               pready
);

  // requests taken but not yet answered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_old_bit) &&
                                $stable(rsp_found_position))
    else $error("response changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response without an outstanding request");

  a_two_max: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !req_ready)
    else $error("request taken with two already outstanding");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_old_bit && rsp_found_position != '0) &&
                  rsp_found_position <= MAP_LIMIT)
    else $error("malformed response");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind bitmap_set_clear_find_engine_unit bscf_checker u_bscf_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_old_bit        (rsp.old_bit),
  .rsp_found_position (rsp.found_position),
  .pready             (pready)
);

`default_nettype wire
